// File: hw/rtl/ptm_pkg.sv
package ptm_pkg;

  localparam int PAGE_BITS  = 12;
  localparam int LEVEL_BITS = 9;
  localparam int ENTRIES    = 512;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MAP   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_LOW_BASE  = 2'd0,
    CFG_KVA_OFS   = 2'd1,
    CFG_DESC_BITS = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_ZERO,
    ST_A_END,
    ST_USER,
    ST_ROOT_WAIT,
    ST_ROOT_NEW,
    ST_WALK_RD,
    ST_WALK_CK,
    ST_LINK,
    ST_LEAF,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/ptm_ram.sv
module ptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/page_table_mapper_with_allocator_core.sv
// Page allocator and four-level page table mapper. Op 0 allocates the lowest free page,
// clears it and returns its physical address; op 1 frees a page by physical address;
// op 2 allocates a user page, walks the task's four table levels (indices from
// vaddr 47:39, 38:30, 29:21, leaf 20:12), creating and clearing missing tables, writes
// the leaf and returns the kernel virtual address. Failure gives ok 0 and address 0.
// One word at a time: the sequencer drives a single-port usage-map RAM, a single-port
// page-word RAM and a root-table RAM. A page scan examines pages one at a time from the
// lowest, a page clear writes its 512 words one at a time, and op 2 makes up to five
// allocations plus the table walk. After reset the usage map is cleared, in_ready low.
// Configuration writes are always taken (cfg_ready high).
module page_table_mapper_with_allocator_core
  import ptm_pkg::*;
#(
  parameter int NUM_PAGES = 64,
  parameter int NUM_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_task_id,
  input  logic [47:0] in_vaddr,
  input  logic [47:0] in_page_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_address,
  output logic        out_ok,
  output logic [2:0]  out_tables_created,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int PIW = $clog2(NUM_PAGES);
  localparam int TW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int WAW = PIW + LEVEL_BITS;

  // configuration
  logic [47:0] base_r;
  logic [63:0] kva_r;
  logic [11:0] desc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 48'h400000;
      kva_r  <= 64'hFFFF000000000000;
      desc_r <= 12'd3;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOW_BASE:  base_r <= cfg_data[47:0];
        CFG_KVA_OFS:   kva_r  <= cfg_data;
        CFG_DESC_BITS: desc_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t          state_r, state_nxt, ret_r, ret_nxt;
  logic [PIW:0]    cnt_r, cnt_nxt;
  logic [8:0]      wcnt_r, wcnt_nxt;
  logic [PIW-1:0]  idx_r, idx_nxt;
  logic [PIW-1:0]  tbl_r, tbl_nxt;
  logic            aok_r, aok_nxt;
  logic [63:0]     phys_r, phys_nxt;
  logic [63:0]     uphys_r, uphys_nxt;
  logic [1:0]      level_r, level_nxt;
  logic [2:0]      created_r, created_nxt;
  op_t             op_r, op_nxt;
  logic [3:0]      task_r, task_nxt;
  logic [47:0]     va_r, va_nxt;
  logic [47:0]     pa_r, pa_nxt;
  logic [63:0]     res_addr_r, res_addr_nxt;
  logic            res_ok_r, res_ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_addr_r, out_addr_nxt;
  logic            out_ok_r, out_ok_nxt;
  logic [2:0]      out_cr_r, out_cr_nxt;
  logic [NUM_TASKS-1:0] rvld_r, rvld_nxt;

  // memory ports
  logic           u_we, u_wd, u_rd;
  logic [PIW-1:0] u_addr;
  logic           w_we;
  logic [WAW-1:0] w_addr;
  logic [63:0]    w_wd, w_rd;
  logic           rt_we;
  logic [TW-1:0]  rt_addr;
  logic [PIW-1:0] rt_wd, rt_rd;

  ptm_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_usage (
    .clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wd), .rdata(u_rd)
  );

  ptm_ram #(.WIDTH(64), .DEPTH(NUM_PAGES * ENTRIES)) u_words (
    .clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wd), .rdata(w_rd)
  );

  ptm_ram #(.WIDTH(PIW), .DEPTH(NUM_TASKS)) u_root (
    .clk(clk), .we(rt_we), .addr(rt_addr), .wdata(rt_wd), .rdata(rt_rd)
  );

  // helpers
  logic [TW-1:0] task_idx;
  logic [8:0]    ei;
  logic [48:0]   fdiff;
  logic [63:0]   slot_pa;
  logic [64:0]   sdiff;

  assign task_idx = TW'(task_r);
  assign fdiff    = {1'b0, pa_r} - {1'b0, base_r};
  assign slot_pa  = {w_rd[63:PAGE_BITS], 12'd0};
  assign sdiff    = {1'b0, slot_pa} - {17'd0, base_r};

  always_comb begin
    case (level_r)
      2'd3:    ei = va_r[47:39];
      2'd2:    ei = va_r[38:30];
      default: ei = va_r[29:21];
    endcase
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_address        = out_addr_r;
  assign out_ok             = out_ok_r;
  assign out_tables_created = out_cr_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    wcnt_nxt      = wcnt_r;
    idx_nxt       = idx_r;
    tbl_nxt       = tbl_r;
    aok_nxt       = aok_r;
    phys_nxt      = phys_r;
    uphys_nxt     = uphys_r;
    level_nxt     = level_r;
    created_nxt   = created_r;
    op_nxt        = op_r;
    task_nxt      = task_r;
    va_nxt        = va_r;
    pa_nxt        = pa_r;
    res_addr_nxt  = res_addr_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_addr_nxt  = out_addr_r;
    out_ok_nxt    = out_ok_r;
    out_cr_nxt    = out_cr_r;
    rvld_nxt      = rvld_r;
    u_we          = 1'b0;
    u_wd          = 1'b0;
    u_addr        = cnt_r[PIW-1:0];
    w_we          = 1'b0;
    w_addr        = {tbl_r, ei};
    w_wd          = 64'd0;
    rt_we         = 1'b0;
    rt_addr       = task_idx;
    rt_wd         = idx_r;

    unique case (state_r)
      ST_CLEAR: begin
        u_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (PIW+1)'(NUM_PAGES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = op_t'(in_op);
          task_nxt     = in_task_id;
          va_nxt       = in_vaddr;
          pa_nxt       = in_page_addr;
          created_nxt  = 3'd0;
          res_addr_nxt = 64'd0;
          res_ok_nxt   = 1'b0;
          cnt_nxt      = '0;
          unique case (op_t'(in_op))
            OP_ALLOC: begin
              ret_nxt   = ST_A_END;
              state_nxt = ST_SCAN_RD;
            end
            OP_FREE: state_nxt = ST_FREE;
            OP_MAP: begin
              if (9'(in_task_id) < 9'(NUM_TASKS)) begin
                ret_nxt   = ST_USER;
                state_nxt = ST_SCAN_RD;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FREE: begin
        if (!fdiff[48] && fdiff[47:PAGE_BITS] < 36'(NUM_PAGES)) begin
          u_we   = 1'b1;
          u_addr = fdiff[PIW+PAGE_BITS-1:PAGE_BITS];
        end
        res_ok_nxt = 1'b1;
        state_nxt  = ST_DONE;
      end
      // lowest-free search, one page at a time
      ST_SCAN_RD: begin
        if (cnt_r == (PIW+1)'(NUM_PAGES)) begin
          aok_nxt   = 1'b0;
          state_nxt = ret_r;
        end else begin
          state_nxt = ST_SCAN_CK;
        end
      end
      ST_SCAN_CK: begin
        if (!u_rd) begin
          u_we      = 1'b1;
          u_wd      = 1'b1;
          idx_nxt   = cnt_r[PIW-1:0];
          phys_nxt  = {16'd0, base_r} + (64'(cnt_r[PIW-1:0]) << PAGE_BITS);
          wcnt_nxt  = 9'd0;
          state_nxt = ST_ZERO;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_ZERO: begin
        w_we     = 1'b1;
        w_addr   = {idx_r, wcnt_r};
        wcnt_nxt = wcnt_r + 1'b1;
        if (wcnt_r == 9'(ENTRIES - 1)) begin
          aok_nxt   = 1'b1;
          state_nxt = ret_r;
        end
      end
      ST_A_END: begin
        if (aok_r) begin
          res_addr_nxt = phys_r;
          res_ok_nxt   = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_USER: begin
        uphys_nxt = phys_r;
        if (!aok_r) begin
          state_nxt = ST_DONE;
        end else if (rvld_r[task_idx]) begin
          state_nxt = ST_ROOT_WAIT;
        end else begin
          cnt_nxt   = '0;
          ret_nxt   = ST_ROOT_NEW;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_ROOT_WAIT: begin
        tbl_nxt   = rt_rd;
        level_nxt = 2'd3;
        state_nxt = ST_WALK_RD;
      end
      ST_ROOT_NEW: begin
        if (!aok_r) begin
          state_nxt = ST_DONE;
        end else begin
          rt_we              = 1'b1;
          rvld_nxt[task_idx] = 1'b1;
          created_nxt        = 3'd1;
          tbl_nxt            = idx_r;
          level_nxt          = 2'd3;
          state_nxt          = ST_WALK_RD;
        end
      end
      ST_WALK_RD: state_nxt = ST_WALK_CK;
      ST_WALK_CK: begin
        if (w_rd == 64'd0) begin
          cnt_nxt   = '0;
          ret_nxt   = ST_LINK;
          state_nxt = ST_SCAN_RD;
        end else if (!sdiff[64] && sdiff[63:PAGE_BITS] < 52'(NUM_PAGES)) begin
          tbl_nxt   = sdiff[PIW+PAGE_BITS-1:PAGE_BITS];
          level_nxt = level_r - 1'b1;
          state_nxt = (level_r == 2'd1) ? ST_LEAF : ST_WALK_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LINK: begin
        if (!aok_r) begin
          state_nxt = ST_DONE;
        end else begin
          w_we        = 1'b1;
          w_wd        = phys_r | {52'd0, desc_r};
          created_nxt = created_r + 1'b1;
          tbl_nxt     = idx_r;
          level_nxt   = level_r - 1'b1;
          state_nxt   = (level_r == 2'd1) ? ST_LEAF : ST_WALK_RD;
        end
      end
      ST_LEAF: begin
        w_we      = 1'b1;
        w_addr    = {tbl_r, va_r[20:12]};
        w_wd      = uphys_r | {52'd0, desc_r};
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        res_addr_nxt = uphys_r + kva_r;
        res_ok_nxt   = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_ok_nxt    = res_ok_r;
          out_cr_nxt    = created_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ret_r       <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rvld_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rvld_r      <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wcnt_r     <= wcnt_nxt;
    idx_r      <= idx_nxt;
    tbl_r      <= tbl_nxt;
    aok_r      <= aok_nxt;
    phys_r     <= phys_nxt;
    uphys_r    <= uphys_nxt;
    level_r    <= level_nxt;
    created_r  <= created_nxt;
    op_r       <= op_nxt;
    task_r     <= task_nxt;
    va_r       <= va_nxt;
    pa_r       <= pa_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    out_addr_r <= out_addr_nxt;
    out_ok_r   <= out_ok_nxt;
    out_cr_r   <= out_cr_nxt;
  end

`ifndef SYNTHESIS
  a_created_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cr_r <= 3'd4)
    else $error("tables_created above four");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_addr_r == 64'd0)
    else $error("failed word carries an address");

  a_word_wr: assert property (@(posedge clk) disable iff (!rst_n)
    w_we |-> (state_r == ST_ZERO || state_r == ST_LINK || state_r == ST_LEAF))
    else $error("page word written outside clear, link or leaf");

  a_alloc_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_RD) |-> (op_r == OP_ALLOC || op_r == OP_MAP))
    else $error("page scan for an op that allocates nothing");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ptm_pkg::*;

  localparam int NPAGES      = 64;
  localparam int NTASKS      = 16;
  localparam int STALL_LIMIT = 20000;   // cycles with no word moving on any channel
  localparam int HOLD_CYCLES = 4000;    // one long receiver hold-off
  localparam int DRAIN_WAIT  = 50;

  typedef struct packed {
    logic [63:0] address;
    logic        ok;
    logic [2:0]  created;
  } map_result_t;

  typedef struct {
    op_t         op;
    logic [3:0]  task_id;
    logic [47:0] va;
    logic [47:0] pa;
    bit          typed;
    map_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [3:0]  in_task_id = '0;
  logic [47:0] in_vaddr = '0;
  logic [47:0] in_page_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_address;
  logic        out_ok;
  logic [2:0]  out_tables_created;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  page_table_mapper_with_allocator_core dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: usage bits, page contents, task roots, registers
  // ---------------------------------------------------------------------------
  bit          page_used [NPAGES];
  logic [63:0] page_mem  [NPAGES][512];
  bit          root_valid[NTASKS];
  int          root_page [NTASKS];
  logic [47:0] mem_base  = 48'h40_0000;
  logic [63:0] kva_ofs   = 64'hFFFF_0000_0000_0000;
  logic [11:0] desc_bits = 12'd3;

  map_result_t expected_q[$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          hold_done  = 1'b0;
  logic [26:0] va_prefix[4];   // shared upper VA bits so walks reuse tables

  function automatic logic [63:0] page_phys(int idx);
    return {16'h0, mem_base} + (64'(idx) << PAGE_BITS);
  endfunction

  // lowest free page: mark used, clear it
  function automatic bit grab_page(output int idx);
    for (int i = 0; i < NPAGES; i++) begin
      if (!page_used[i]) begin
        page_used[i] = 1'b1;
        for (int j = 0; j < ENTRIES; j++) page_mem[i][j] = '0;
        idx = i;
        return 1'b1;
      end
    end
    idx = 0;
    return 1'b0;
  endfunction

  function automatic map_result_t predict_result(op_t op, logic [3:0] tid,
                                                 logic [47:0] va, logic [47:0] pa_in);
    map_result_t r;
    int          idx, user, tbl, ei;
    bit          good;
    logic [63:0] off, slot, pa;
    r = '0;
    case (op)
      OP_ALLOC: begin
        if (grab_page(idx)) begin
          r.address = page_phys(idx);
          r.ok = 1'b1;
        end
      end
      OP_FREE: begin
        off = {16'h0, pa_in} - {16'h0, mem_base};
        if (pa_in >= mem_base && (off >> PAGE_BITS) < NPAGES)
          page_used[int'(off >> PAGE_BITS)] = 1'b0;
        r.ok = 1'b1;
      end
      OP_MAP: begin
        if (grab_page(user)) begin
          good = 1'b1;
          tbl = 0;
          if (!root_valid[tid]) begin
            if (grab_page(idx)) begin
              root_valid[tid] = 1'b1;
              root_page[tid] = idx;
              r.created = 3'd1;
            end else begin
              good = 1'b0;
            end
          end
          if (good) tbl = root_page[tid];
          for (int lvl = 3; good && lvl >= 1; lvl--) begin
            ei = int'((va >> (PAGE_BITS + LEVEL_BITS * lvl)) & 48'h1FF);
            slot = page_mem[tbl][ei];
            if (slot == '0) begin
              if (grab_page(idx)) begin
                page_mem[tbl][ei] = page_phys(idx) | {52'h0, desc_bits};
                r.created++;
                tbl = idx;
              end else begin
                good = 1'b0;
              end
            end else begin
              pa = {slot[63:12], 12'h0};
              off = pa - {16'h0, mem_base};
              if (pa >= {16'h0, mem_base} && (off >> PAGE_BITS) < NPAGES)
                tbl = int'(off >> PAGE_BITS);
              else
                good = 1'b0;
            end
          end
          if (good) begin
            page_mem[tbl][va[20:12]] = page_phys(user) | {52'h0, desc_bits};
            r.address = page_phys(user) + kva_ofs;
            r.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit idle_now();
    if (items_sent >= 100 && items_sent < 160) return 1'b0;   // no-gap stretch
    return $urandom_range(99) < 17;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one input word; called and returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(op_t op, logic [3:0] tid, logic [47:0] va, logic [47:0] pa,
                           bit typed, map_result_t typed_res);
    map_result_t r;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    r = predict_result(op, tid, va, pa);
    expected_q.push_back(typed ? typed_res : r);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_task_id   <= tid;
    in_vaddr     <= va;
    in_page_addr <= pa;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(bit no_map);
    op_t         op;
    logic [3:0]  tid;
    logic [47:0] va, pa;
    int          pick, idx;
    pick = $urandom_range(99);
    if (pick < 20)      op = OP_ALLOC;
    else if (pick < 50) op = OP_FREE;
    else if (pick < 93) op = no_map ? OP_ALLOC : OP_MAP;
    else                op = OP_NONE;
    tid = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom);
    if ($urandom_range(99) < 70)
      va = {va_prefix[$urandom_range(3)], 9'($urandom), 12'($urandom)};
    else
      va = {16'($urandom), 32'($urandom)};
    if ($urandom_range(99) < 75) begin
      idx = $urandom_range(NPAGES - 1);
      for (int t = 0; t < 8 && !page_used[idx]; t++) idx = $urandom_range(NPAGES - 1);
      pa = 48'(page_phys(idx)) + 48'($urandom_range(4095));
    end else begin
      pa = {16'($urandom), 32'($urandom)};
    end
    send_word(op, tid, va, pa, 1'b0, '0);
  endtask

  // register writes only with nothing in flight; the last input word is withdrawn first
  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LOW_BASE:  mem_base  = data[47:0];
      CFG_KVA_OFS:   kva_ofs   = data;
      CFG_DESC_BITS: desc_bits = data[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off so the block stalls
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= 60) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= !idle_now();
    end
  end

  // ---------------------------------------------------------------------------
  // Result check and watchdog
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    map_result_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("** page_table_mapper_with_allocator_core: FAILED **");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: address %h ok %b tables %0d",
                     out_address, out_ok, out_tables_created);
        end else begin
          want = expected_q.pop_front();
          if (out_address !== want.address || out_ok !== want.ok ||
              out_tables_created !== want.created) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp address %h ok %b tables %0d / got %h %b %0d",
                       want.address, want.ok, want.created,
                       out_address, out_ok, out_tables_created);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  stim_row_t rows[$];

  function automatic stim_row_t mk(op_t op, logic [3:0] tid, logic [47:0] va,
                                   logic [47:0] pa, bit typed, logic [63:0] a,
                                   logic ok, logic [2:0] c);
    stim_row_t s;
    s.op = op; s.task_id = tid; s.va = va; s.pa = pa; s.typed = typed;
    s.res.address = a; s.res.ok = ok; s.res.created = c;
    return s;
  endfunction

  initial begin
    for (int i = 0; i < 4; i++) va_prefix[i] = 27'($urandom);
    // directed part, reset register values
    rows.push_back(mk(OP_NONE, 4'hF, '1, '1, 1, '0, 0, 0));
    rows.push_back(mk(OP_FREE, 0, 0, 0, 1, '0, 1, 0));                  // below base
    rows.push_back(mk(OP_ALLOC, 0, 0, 0, 1, 64'h40_0000, 1, 0));
    rows.push_back(mk(OP_MAP, 0, 0, 0, 1, 64'hFFFF_0000_0040_1000, 1, 4));
    rows.push_back(mk(OP_MAP, 0, 48'h1000, 0, 1, 64'hFFFF_0000_0040_6000, 1, 0));
    rows.push_back(mk(OP_MAP, 4'hF, '1, 0, 0, '0, 0, 0));
    rows.push_back(mk(OP_FREE, 0, 0, 48'h40_0FFF, 1, '0, 1, 0));        // unaligned
    rows.push_back(mk(OP_ALLOC, 0, 0, 0, 1, 64'h40_0000, 1, 0));
    rows.push_back(mk(OP_FREE, 0, 0, 48'h44_0000, 1, '0, 1, 0));        // past last page
    rows.push_back(mk(OP_FREE, 0, 0, '1, 1, '0, 1, 0));
    rows.push_back(mk(OP_MAP, 0, 0, 0, 0, '0, 0, 0));                   // leaf overwrite
    rows.push_back(mk(OP_MAP, 1, 48'h8000_0000_0000, 0, 0, '0, 0, 0));
    rows.push_back(mk(OP_MAP, 1, 48'h8000_4020_1000, 0, 0, '0, 0, 0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i])
      send_word(rows[i].op, rows[i].task_id, rows[i].va, rows[i].pa,
                rows[i].typed, rows[i].res);
    repeat (60) send_random(1'b0);

    // low extremes; old entries now fall outside managed memory
    write_reg(CFG_LOW_BASE, 64'h0);
    write_reg(CFG_KVA_OFS, 64'h0);
    write_reg(CFG_DESC_BITS, 64'h0);
    repeat (50) send_random(1'b0);

    // high extremes; unaligned base, so no walks here
    write_reg(CFG_LOW_BASE, 64'hFFFF_FFFF_FFFF);
    write_reg(CFG_KVA_OFS, '1);
    write_reg(CFG_DESC_BITS, 64'hFFF);
    repeat (20) send_random(1'b1);

    write_reg(CFG_LOW_BASE, 64'hFFFF_FFFF_F000);
    write_reg(CFG_KVA_OFS, {$urandom, $urandom});
    write_reg(CFG_DESC_BITS, 64'($urandom_range(4095)));
    repeat (40) send_random(1'b0);

    // back to the reset base: earlier tables become reachable again
    write_reg(CFG_LOW_BASE, 64'h40_0000);
    write_reg(CFG_DESC_BITS, 64'd3);
    repeat (50) send_random(1'b0);
    in_valid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("** page_table_mapper_with_allocator_core: PASSED **");
    else
      $display("** page_table_mapper_with_allocator_core: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ptm_pkg.sv
hw/rtl/ptm_ram.sv
hw/rtl/page_table_mapper_with_allocator_core.sv
dv/testbench.sv
